// File: hdl/iqw_pkg.sv
// ----------------------------------------------------------------------------
// iqw_pkg
// Shared types, codes and defaults for the interacting quantum walk step.
// ----------------------------------------------------------------------------
package iqw_pkg;

  localparam int GRID_SIZE_DEF = 128;
  localparam int AMP_BITS_DEF  = 24;
  localparam int PHASE_W       = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int PROB_W        = 24;

  localparam logic signed [PHASE_W-1:0] PHASE_COS_RST = -24'sd2965821;
  localparam logic signed [PHASE_W-1:0] PHASE_SIN_RST = 24'sd2965821;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SIN = 2'd1;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] cell_row;
    logic [6:0] cell_col;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PROB_W-1:0] probability;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INIT, S_STEP, S_DRAIN, S_READ, S_SQ, S_RESP
  } state_t;

  // sign of Hadamard entry (row k, column j): negative on odd parity of k & j
  function automatic logic had_neg(input logic [1:0] k, input logic [1:0] j);
    return ^(k & j);
  endfunction

endpackage

// File: hdl/iqw_chan.sv
// ----------------------------------------------------------------------------
// iqw_chan
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface iqw_chan #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/interacting_quantum_walk_step.sv
// ----------------------------------------------------------------------------
// interacting_quantum_walk_step
// Two interacting walkers on a square grid, amplitudes in two cell memories.
// ----------------------------------------------------------------------------
// One word in, one word out, one operation at a time. Each memory row holds
// the four complex amplitudes of one cell; two banks alternate as current and
// next grid. After reset a clearing pass over all 4**ceil(log2(GRID_SIZE))
// rows runs before the first word is taken. Init makes the same sweep.
// Step reads one diagonal neighbour row per cycle on the single read port.
// Read squares each of the eight amplitude parts of the cell once and sums
// the squares.
module interacting_quantum_walk_step import iqw_pkg::*; #(
  parameter int GRID_SIZE      = GRID_SIZE_DEF,
  parameter int AMPLITUDE_BITS = AMP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  iqw_chan.sink                req,
  iqw_chan.source              rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PHASE_W-1:0]   cfg_data
);

  localparam int A     = AMPLITUDE_BITS;
  localparam int RB    = $clog2(GRID_SIZE);
  localparam int AW    = 2 * RB;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = 8 * A;
  localparam int SUMW  = 2 * A + 5;
  localparam int SH    = 2 * A - 26;
  localparam int SHR   = (SH > 0) ? SH : 0;
  localparam int SHL   = (SH < 0) ? -SH : 0;
  localparam logic [RB-1:0] LAST_IN = RB'(GRID_SIZE - 2);
  localparam logic [AW-1:0] CENTER  = {RB'(GRID_SIZE / 2), RB'(GRID_SIZE / 2)};
  localparam logic signed [A+26:0] HALF23 = (A+27)'(1) << 22;
  localparam logic signed [A+3:0]  AMAX = (A+4)'((64'(1) << (A - 1)) - 1);
  localparam logic signed [A+3:0]  AMIN = -AMAX - (A+4)'(1);

  state_t state, state_next;

  logic signed [PHASE_W-1:0] phase_cos, phase_sin;
  logic                      cur;
  logic [AW-1:0]             clr_addr;
  logic [AW-1:0]             cell_addr;
  logic [RB-1:0]             r, c;
  logic [1:0]                k;
  logic [3:0]                j;
  logic [1:0]                status;
  logic [SUMW-1:0]           acc;
  logic [2*A-1:0]            sq;
  logic                      rsp_v;
  rsp_t                      rsp_data;

  logic [CW-1:0] mem0 [DEPTH];
  logic [CW-1:0] mem1 [DEPTH];
  logic [CW-1:0] rd0, rd1, rd;
  logic [AW-1:0] ra, wa;
  logic          we0, we1;
  logic [CW-1:0] wd0, wd1, center_row, row_out;

  // pipeline stages
  logic                va, vb, vc;
  logic [1:0]          ka, kb, kc;
  logic                diag_a, diag_b, diag_c;
  logic [AW-1:0]       dst_a, dst_b, dst_c;
  logic signed [A+1:0] sre, sim, sre_b, sim_b, sre_c, sim_c;
  logic signed [A+25:0] pcc, pss, pcs, psc;
  logic signed [A+3:0] vre, vim;
  logic [A-1:0]        ore, oim;
  logic [2*A-1:0]      comp_buf [3];

  logic accept, load, in_range;
  logic [RB-1:0] nr, nc;

  assign accept   = req.valid && req.ready;
  assign load     = (state == S_RESP) && (!rsp_v || rsp.ready);
  assign in_range = (32'(req.data.cell_row) < GRID_SIZE) &&
                    (32'(req.data.cell_col) < GRID_SIZE);
  assign nr = k[1] ? r - RB'(1) : r + RB'(1);
  assign nc = k[0] ? c - RB'(1) : c + RB'(1);
  assign ra = (state == S_STEP) ? {nr, nc} : cell_addr;
  assign rd = cur ? rd1 : rd0;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      center_row[i*2*A +: 2*A] = {A'(0), A'(1) << (A - 3)};
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa] <= wd0;
    end
    rd0 <= mem0[ra];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa] <= wd1;
    end
    rd1 <= mem1[ra];
  end

  // Hadamard row sums
  always_comb begin
    sre = '0;
    sim = '0;
    for (int i = 0; i < 4; i++) begin
      if (had_neg(ka, 2'(i))) begin
        sre = sre - (A+2)'($signed(rd[i*2*A +: A]));
        sim = sim - (A+2)'($signed(rd[i*2*A+A +: A]));
      end else begin
        sre = sre + (A+2)'($signed(rd[i*2*A +: A]));
        sim = sim + (A+2)'($signed(rd[i*2*A+A +: A]));
      end
    end
  end

  // rounding and saturation
  always_comb begin
    logic signed [A+26:0] tre, tim;
    logic signed [A+2:0]  hre, him;
    tre = (A+27)'(pcc) - (A+27)'(pss) + HALF23;
    tim = (A+27)'(pcs) + (A+27)'(psc) + HALF23;
    hre = (A+3)'(sre_c) + (A+3)'(1);
    him = (A+3)'(sim_c) + (A+3)'(1);
    if (diag_c) begin
      vre = (A+4)'(tre >>> 23);
      vim = (A+4)'(tim >>> 23);
    end else begin
      vre = (A+4)'(hre >>> 1);
      vim = (A+4)'(him >>> 1);
    end
    ore = (vre > AMAX) ? A'(AMAX) : (vre < AMIN) ? A'(AMIN) : A'(vre);
    oim = (vim > AMAX) ? A'(AMAX) : (vim < AMIN) ? A'(AMIN) : A'(vim);
    row_out = {oim, ore, comp_buf[2], comp_buf[1], comp_buf[0]};
  end

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa  = clr_addr;
    wd0 = '0;
    wd1 = '0;
    if (state == S_CLEAR || state == S_INIT) begin
      we0 = 1'b1;
      we1 = 1'b1;
      if (state == S_INIT && clr_addr == CENTER) begin
        if (cur) begin
          wd1 = center_row;
        end else begin
          wd0 = center_row;
        end
      end
    end else if (vc && kc == 2'd3) begin
      wa  = dst_c;
      wd0 = row_out;
      wd1 = row_out;
      we0 = cur;
      we1 = !cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          unique case (req.data.operation)
            OP_INIT: state_next = S_INIT;
            OP_STEP: state_next = S_STEP;
            OP_READ: state_next = in_range ? S_READ : S_RESP;
            default: state_next = S_RESP;
          endcase
        end
      end
      S_INIT: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_RESP;
        end
      end
      S_STEP: begin
        if (k == 2'd3 && c == LAST_IN && r == LAST_IN) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!va && !vb && !vc) begin
          state_next = S_RESP;
        end
      end
      S_READ:  state_next = S_SQ;
      S_SQ: begin
        if (j == 4'd8) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_v || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_cos <= PHASE_COS_RST;
      phase_sin <= PHASE_SIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_COS: phase_cos <= cfg_data;
        CFG_PHASE_SIN: phase_sin <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= 1'b0;
      clr_addr <= '0;
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      rsp_v    <= 1'b0;
    end else begin
      if (state == S_CLEAR || state == S_INIT) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_DRAIN && !va && !vb && !vc) begin
        cur <= !cur;
      end
      va <= (state == S_STEP);
      vb <= va;
      vc <= vb;
      if (load) begin
        rsp_v <= 1'b1;
      end else if (rsp.ready) begin
        rsp_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= req.data.operation;
      cell_addr <= {RB'(req.data.cell_row), RB'(req.data.cell_col)};
      acc       <= '0;
      r         <= RB'(1);
      c         <= RB'(1);
      k         <= 2'd0;
      j         <= 4'd0;
    end
    if (state == S_STEP) begin
      k <= k + 2'd1;
      if (k == 2'd3) begin
        if (c == LAST_IN) begin
          c <= RB'(1);
          r <= r + RB'(1);
        end else begin
          c <= c + RB'(1);
        end
      end
    end
    ka     <= k;
    diag_a <= (r == c);
    dst_a  <= {r, c};
    kb     <= ka;
    diag_b <= diag_a;
    dst_b  <= dst_a;
    sre_b  <= sre;
    sim_b  <= sim;
    kc     <= kb;
    diag_c <= diag_b;
    dst_c  <= dst_b;
    sre_c  <= sre_b;
    sim_c  <= sim_b;
    pcc    <= sre_b * phase_cos;
    pss    <= sim_b * phase_sin;
    pcs    <= sre_b * phase_sin;
    psc    <= sim_b * phase_cos;
    if (vc) begin
      case (kc)
        2'd0: comp_buf[0] <= {oim, ore};
        2'd1: comp_buf[1] <= {oim, ore};
        2'd2: comp_buf[2] <= {oim, ore};
        default: ;
      endcase
    end
    if (state == S_SQ) begin
      j <= j + 4'd1;
      if (j != 4'd8) begin
        sq <= $signed(rd[j[2:0]*A +: A]) * $signed(rd[j[2:0]*A +: A]);
      end
      if (j != 4'd0) begin
        acc <= acc + (SUMW'(sq >> SHR) << SHL);
      end
    end
    if (load) begin
      rsp_data.status      <= status;
      rsp_data.probability <= (acc > SUMW'(24'hFFFFFF)) ? 24'hFFFFFF : acc[PROB_W-1:0];
    end
  end

  assign rsp.valid = rsp_v;
  assign rsp.data  = rsp_data;

endmodule
